@@ rtl/core/nsp_pkg.sv @@
// nsp_pkg: shared types and constants for the numeric string parser
package nsp_pkg;

	localparam int CHAR_W = 8;
	localparam int VALUE_W = 32;
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POSITION_LIMIT = 4'd11;
	localparam logic [POS_W-1:0] HEX_PREFIX_LEN = 4'd2;
	localparam int KILO_SHIFT = 10;
	localparam int MEGA_SHIFT = 20;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LX = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LK = 8'h6b;
	localparam logic [CHAR_W-1:0] CH_UK = 8'h4b;
	localparam logic [CHAR_W-1:0] CH_LM = 8'h6d;
	localparam logic [CHAR_W-1:0] CH_UM = 8'h4d;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic       is_nul;
		logic       is_dec;
		logic       is_hex;
		logic       is_x;
		logic       is_k;
		logic       is_m;
		logic [3:0] digit;
	} char_class_t;

endpackage

@@ rtl/core/nsp_if.sv @@
// nsp_if: valid/ready channel interfaces for characters and parse results
interface nsp_char_if import nsp_pkg::*;;
	logic  valid;
	logic  ready;
	char_t char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

interface nsp_result_if import nsp_pkg::*;;
	logic   valid;
	logic   ready;
	value_t value;
	logic   ok;

	modport source(output valid, output value, output ok, input ready);
	modport sink(input valid, input value, input ok, output ready);
endinterface

@@ rtl/core/nsp_char_decode.sv @@
// nsp_char_decode: classifies one ascii byte and extracts its digit value
module nsp_char_decode import nsp_pkg::*; (
	input  char_t       c,
	output char_class_t cls
);

	logic dec, lower, upper;

	always_comb begin
		dec = (c >= CH_0) && (c <= CH_9);
		lower = (c >= CH_LA) && (c <= CH_LF);
		upper = (c >= CH_UA) && (c <= CH_UF);
		cls.is_nul = (c == CH_NUL);
		cls.is_dec = dec;
		cls.is_hex = dec || lower || upper;
		cls.is_x = (c == CH_LX) || (c == CH_UX);
		cls.is_k = (c == CH_LK) || (c == CH_UK);
		cls.is_m = (c == CH_LM) || (c == CH_UM);
		if (dec) begin
			cls.digit = c[3:0];
		end else begin
			cls.digit = c[3:0] + 4'd9;
		end
	end

endmodule

@@ rtl/core/numeric_string_parser_top.sv @@
// numeric_string_parser_top: byte-serial ascii hex/decimal parser with k/m suffix
//
//  channel    dir  payload          request
//  char_ch    in   char_in[7:0]     one string byte, zero ends the string
//  result_ch  out  value[31:0], ok  one per string, on the zero byte
//
//  one byte accepted per cycle unless stalled; parse state updates in that cycle
//  a result appears in the output register the cycle after its zero byte
//  char_ch.ready drops only while a result is held and result_ch.ready is low
//  arst_n clears the parse state and the output valid
module numeric_string_parser_top import nsp_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	nsp_char_if.sink      char_ch,
	nsp_result_if.source  result_ch
);

	char_class_t cls;
	logic        accept;
	logic        out_valid_q;
	value_t      out_value_q;
	logic        out_ok_q;

	pos_t   pos_q, pos_n, pos_inc;
	logic   hex_q, hex_n;
	value_t acc_q, acc_n;
	logic   dec_q, dec_n;
	logic   dok_q, dok_n;
	logic   advance, good;

	nsp_char_decode u_decode (
		.c   (char_ch.char_in),
		.cls (cls)
	);

	assign char_ch.ready = !out_valid_q || result_ch.ready;
	assign accept = char_ch.valid && char_ch.ready;

	assign result_ch.valid = out_valid_q;
	assign result_ch.value = out_value_q;
	assign result_ch.ok = out_ok_q;

	always_comb begin
		good = dec_q ? dok_q : !(hex_q && (pos_q == HEX_PREFIX_LEN));
		pos_n = pos_q;
		hex_n = hex_q;
		acc_n = acc_q;
		dec_n = dec_q;
		dok_n = dok_q;
		advance = 1'b0;
		pos_inc = (pos_q < POSITION_LIMIT) ? pos_q + 4'd1 : pos_q;
		priority if (cls.is_nul) begin
			pos_n = '0;
			hex_n = 1'b0;
			acc_n = '0;
			dec_n = 1'b0;
			dok_n = 1'b0;
		end else if (dec_q) begin
			// ignore bytes until the terminator
		end else if (pos_q == 4'd1 && !hex_q && acc_q == '0 && cls.is_x) begin
			hex_n = 1'b1;
			advance = 1'b1;
		end else if (hex_q) begin
			if (cls.is_hex) begin
				acc_n = {acc_q[VALUE_W-5:0], cls.digit};
				advance = 1'b1;
			end else begin
				dec_n = 1'b1;
				dok_n = 1'b0;
			end
		end else if (cls.is_k && pos_q != '0) begin
			acc_n = acc_q << KILO_SHIFT;
			dec_n = 1'b1;
			dok_n = 1'b1;
		end else if (cls.is_m && pos_q != '0) begin
			acc_n = acc_q << MEGA_SHIFT;
			dec_n = 1'b1;
			dok_n = 1'b1;
		end else if (cls.is_dec) begin
			acc_n = (acc_q << 3) + (acc_q << 1) + {{(VALUE_W-4){1'b0}}, cls.digit};
			advance = 1'b1;
		end else begin
			dec_n = 1'b1;
			dok_n = 1'b0;
		end
		if (advance) begin
			pos_n = pos_inc;
			if (pos_inc >= POSITION_LIMIT) begin
				dec_n = 1'b1;
				dok_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hex_q <= 1'b0;
			acc_q <= '0;
			dec_q <= 1'b0;
			dok_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_n;
			hex_q <= hex_n;
			acc_q <= acc_n;
			dec_q <= dec_n;
			dok_q <= dok_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && cls.is_nul) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cls.is_nul) begin
			out_value_q <= good ? acc_q : '0;
			out_ok_q <= good;
		end
	end

endmodule

@@ rtl/core/nsp_checker.sv @@
// nsp_checker: port-level assertions for the numeric string parser, bound to the top
module nsp_checker import nsp_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input char_t  char_in,
	input logic   out_valid,
	input logic   out_ready,
	input value_t value,
	input logic   ok
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(ok))
		else $error("result request changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> value == '0)
		else $error("failed parse with nonzero value");

	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && char_in == CH_NUL |=> out_valid)
		else $error("terminator gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && char_in != CH_NUL && !out_valid |=> !out_valid)
		else $error("result without terminator");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while result stalled");

endmodule

bind numeric_string_parser_top nsp_checker u_nsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (char_ch.valid),
	.in_ready  (char_ch.ready),
	.char_in   (char_ch.char_in),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.value     (result_ch.value),
	.ok        (result_ch.ok)
);

@@ tb/testbench.sv @@
// testbench: directed and random string stimulus with a self-checking parse predictor
module testbench import nsp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_LIMIT = 10;
	localparam value_t RADIX_DEC = 32'd10;

	typedef struct packed {
		value_t value;
		logic   ok;
	} parse_result_t;

	typedef struct {
		char_t  ch;
		bit     typed;
		value_t value;
		logic   ok;
	} stim_row_t;

	logic clk;
	logic arst_n;

	nsp_char_if   char_ch();
	nsp_result_if result_ch();

	numeric_string_parser_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_ch   (char_ch),
		.result_ch (result_ch)
	);

	parse_result_t expected_results[$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            src_idle_pct = 0;
	int            sink_stall_pct = 0;

	pos_t   str_pos = '0;
	logic   str_hex = 1'b0;
	value_t str_acc = '0;
	logic   str_decided = 1'b0;
	logic   str_decided_ok = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void parse_char(input char_t c, output bit emits,
			output parse_result_t res);
		logic [3:0] d;
		bit         is_hex_digit;
		bit         advance;
		logic       good;
		emits = 1'b0;
		advance = 1'b0;
		res = '0;
		d = '0;
		is_hex_digit = 1'b1;
		if (c >= CH_0 && c <= CH_9) begin
			d = 4'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = 4'(c - CH_LA) + 4'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = 4'(c - CH_UA) + 4'd10;
		end else begin
			is_hex_digit = 1'b0;
		end
		if (c == CH_NUL) begin
			if (str_decided)
				good = str_decided_ok;
			else if (str_hex && str_pos == HEX_PREFIX_LEN)
				good = 1'b0;
			else
				good = 1'b1;
			res.value = good ? str_acc : '0;
			res.ok = good;
			emits = 1'b1;
			str_pos = '0;
			str_hex = 1'b0;
			str_acc = '0;
			str_decided = 1'b0;
			str_decided_ok = 1'b0;
		end else if (str_decided) begin
			// bytes ignored until the terminator
		end else if (str_pos == 4'd1 && !str_hex && str_acc == '0 &&
				(c == CH_LX || c == CH_UX)) begin
			str_hex = 1'b1;
			advance = 1'b1;
		end else if (str_hex) begin
			if (is_hex_digit) begin
				str_acc = {str_acc[VALUE_W-5:0], d};
				advance = 1'b1;
			end else begin
				str_decided = 1'b1;
				str_decided_ok = 1'b0;
			end
		end else if ((c == CH_LK || c == CH_UK) && str_pos != '0) begin
			str_acc = str_acc << KILO_SHIFT;
			str_decided = 1'b1;
			str_decided_ok = 1'b1;
		end else if ((c == CH_LM || c == CH_UM) && str_pos != '0) begin
			str_acc = str_acc << MEGA_SHIFT;
			str_decided = 1'b1;
			str_decided_ok = 1'b1;
		end else if (c >= CH_0 && c <= CH_9) begin
			str_acc = str_acc * RADIX_DEC + value_t'(c - CH_0);
			advance = 1'b1;
		end else begin
			str_decided = 1'b1;
			str_decided_ok = 1'b0;
		end
		if (advance) begin
			if (str_pos < POSITION_LIMIT)
				str_pos = str_pos + 4'd1;
			if (str_pos >= POSITION_LIMIT) begin
				str_decided = 1'b1;
				str_decided_ok = 1'b0;
			end
		end
	endfunction

	task automatic deliver_char(input char_t c, input bit typed, input value_t typed_value,
			input logic typed_ok);
		bit            emits;
		parse_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_in <= c;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		parse_char(c, emits, res);
		if (emits) begin
			if (typed) begin
				res.value = typed_value;
				res.ok = typed_ok;
			end
			expected_results.push_back(res);
		end
	endtask

	task automatic compose_string(ref char_t text[$]);
		int    kind;
		int    n;
		int    r;
		int    idx;
		int    d;
		char_t c;
		text.delete();
		kind = $urandom_range(99);
		if (kind < 40) begin
			r = $urandom_range(99);
			if (r < 8)
				n = 0;
			else if (r < 88)
				n = $urandom_range(1, 10);
			else
				n = $urandom_range(11, 12);
			repeat (n)
				text.push_back(CH_0 + char_t'($urandom_range(9)));
			if ($urandom_range(99) < 40) begin
				case ($urandom_range(3))
					0: text.push_back(CH_LK);
					1: text.push_back(CH_UK);
					2: text.push_back(CH_LM);
					default: text.push_back(CH_UM);
				endcase
				repeat ($urandom_range(3))
					text.push_back(char_t'($urandom_range(1, 255)));
			end
		end else if (kind < 70) begin
			text.push_back(CH_0);
			text.push_back($urandom_range(1) ? CH_LX : CH_UX);
			r = $urandom_range(99);
			if (r < 8)
				n = 0;
			else if (r < 90)
				n = $urandom_range(1, 8);
			else
				n = 9;
			repeat (n) begin
				d = $urandom_range(15);
				if (d < 10)
					text.push_back(CH_0 + char_t'(d));
				else
					text.push_back(($urandom_range(1) ? CH_LA : CH_UA) + char_t'(d - 10));
			end
			if ($urandom_range(99) < 15)
				text.push_back(char_t'($urandom_range(1, 255)));
		end else if (kind < 85) begin
			n = $urandom_range(1, 8);
			repeat (n)
				text.push_back(CH_0 + char_t'($urandom_range(9)));
			idx = $urandom_range(n - 1);
			text[idx] = char_t'($urandom_range(1, 255));
		end else begin
			repeat ($urandom_range(5)) begin
				case ($urandom_range(13))
					0: c = CH_0;
					1: c = CH_LX;
					2: c = CH_UX;
					3: c = CH_LK;
					4: c = CH_UK;
					5: c = CH_LM;
					6: c = CH_UM;
					7: c = CH_LF + 8'd1;
					8: c = CH_UF + 8'd1;
					9: c = CH_0 - 8'd1;
					10: c = CH_9 + 8'd1;
					default: c = char_t'($urandom_range(1, 255));
				endcase
				text.push_back(c);
			end
		end
	endtask

	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("unexpected result: value %h ok %b", result_ch.value, result_ch.ok);
				mismatches++;
			end else begin
				if (result_ch.value !== expected_results[0].value ||
						result_ch.ok !== expected_results[0].ok) begin
					if (mismatches < REPORT_LIMIT)
						$display("mismatch: expected value %h ok %b, got value %h ok %b",
							expected_results[0].value, expected_results[0].ok,
							result_ch.value, result_ch.ok);
					mismatches++;
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t rows[$];
		char_t     text[$];
		int        phase_items;
		char_ch.valid = 1'b0;
		char_ch.char_in = CH_NUL;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		// empty, empty hex, hex, suffix first, suffix then ignored bytes, too long
		rows = '{
			'{CH_NUL, 1'b1, 32'h0000_0000, 1'b1},
			'{CH_0, 1'b0, '0, 1'b0}, '{CH_UX, 1'b0, '0, 1'b0},
			'{CH_NUL, 1'b1, 32'h0000_0000, 1'b0},
			'{CH_0, 1'b0, '0, 1'b0}, '{CH_LX, 1'b0, '0, 1'b0},
			'{CH_LF, 1'b0, '0, 1'b0}, '{CH_UF, 1'b0, '0, 1'b0},
			'{CH_NUL, 1'b1, 32'h0000_00ff, 1'b1},
			'{CH_LK, 1'b0, '0, 1'b0},
			'{CH_NUL, 1'b1, 32'h0000_0000, 1'b0},
			'{CH_0 + 8'd7, 1'b0, '0, 1'b0}, '{CH_UM, 1'b0, '0, 1'b0},
			'{8'hff, 1'b0, '0, 1'b0},
			'{CH_NUL, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0}, '{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0}, '{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0}, '{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0}, '{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0}, '{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_0 + 8'd1, 1'b0, '0, 1'b0},
			'{CH_NUL, 1'b1, 32'h0000_0000, 1'b0}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			deliver_char(rows[i].ch, rows[i].typed, rows[i].value, rows[i].ok);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 61; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 61; end
				default: begin src_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 4) begin
				compose_string(text);
				text.push_back(CH_NUL);
				foreach (text[j]) begin
					deliver_char(text[j], 1'b0, '0, 1'b0);
					phase_items++;
				end
			end
		end

		@(negedge clk);
		char_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/nsp_pkg.sv
rtl/core/nsp_if.sv
rtl/core/nsp_char_decode.sv
rtl/core/numeric_string_parser_top.sv
rtl/core/nsp_checker.sv
tb/testbench.sv
